// ===== hdl/pqn_pkg.sv =====
// Shared types, constants and table builders for the polyphonic quadrature NCO.
package pqn_pkg;

    localparam int PQN_VOICES      = 16;
    localparam int PQN_SINE_DEPTH  = 1024;
    localparam int PQN_EXP_DEPTH   = 256;

    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam longint unsigned PIH_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam logic [31:0] RST_BASE_INC  = 32'd42852282;
    localparam logic [15:0] RST_LOG2_BASE = 16'd16384;
    localparam logic [17:0] RST_TONE      = 18'h3FA00;
    localparam logic [15:0] RST_CV2_SCALE = 16'd32768;
    localparam logic [31:0] RST_PH_OFS    = 32'd1073741824;
    localparam logic [31:0] RST_RANGE_A   = 32'd671143936;
    localparam logic [31:0] RST_RANGE_B   = 32'd3623888896;

    // +-12 V in volts * 2048
    localparam logic signed [19:0] SUM_LIMIT = 20'sd24576;

    typedef enum logic [2:0] {
        CFG_BASE_INC  = 3'd0,
        CFG_LOG2_BASE = 3'd1,
        CFG_TONE      = 3'd2,
        CFG_CV2_SCALE = 3'd3,
        CFG_PH_OFS    = 3'd4,
        CFG_RANGE_A   = 3'd5,
        CFG_RANGE_B   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        base_increment;
        logic [15:0]        log2_base;
        logic signed [17:0] tone_offset;
        logic [15:0]        cv2_scale;
        logic [31:0]        phase_offset;
        logic [31:0]        range_a;
        logic [31:0]        range_b;
    } t_cfg;

    typedef struct packed {
        logic [3:0]         voice;
        logic signed [15:0] cv1;
        logic signed [15:0] cv2;
    } t_in;

    typedef struct packed {
        logic [3:0]         voice_out;
        logic signed [15:0] sine_a;
        logic signed [15:0] sine_b;
        logic signed [15:0] shifted_a;
        logic signed [15:0] shifted_b;
        logic signed [15:0] sum_voltage;
    } t_out;

    // queued work: raw voice and the exponent in volts * 2048
    typedef struct packed {
        logic [3:0]         voice;
        logic signed [19:0] e;
    } t_qitem;

    function automatic longint unsigned quarter_sine_q30(longint unsigned r);
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        theta = (r * PIH_Q30) >> 30;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
        return longint'(sum);
    endfunction

    function automatic logic signed [15:0] sine_entry(int i, int lg);
        longint unsigned    a64;
        longint unsigned    r;
        longint unsigned    s;
        longint unsigned    v;
        logic [31:0]        a;
        logic signed [15:0] vs;
        a64 = (64'(i) << 32) >> lg;
        a   = a64[31:0];
        r   = {34'd0, a[29:0]};
        if (a[30]) r = ONE_Q30 - r;
        s   = quarter_sine_q30(r);
        v   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        vs  = signed'(v[15:0]);
        return a[31] ? -vs : vs;
    endfunction

    function automatic logic [31:0] exp_entry(int i, int lg);
        longint unsigned fr;
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        fr   = (64'(i) << 30) >> lg;
        y    = (fr * LN2_Q30) >> 30;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            sum  = sum + term;
        end
        return sum[31:0];
    endfunction

endpackage

// ===== hdl/poly_quadrature_nco_with_expo_fm_unit.sv =====
// Path from input transfer to result valid: front register, queue, then the
// back-end states; longer while an earlier result is held.
// The back-end sequencer works on one item at a time (octave multiply, increment
// multiply, shift, phase update, four range maps); the queue can take items meanwhile.
// Reset (synchronous, active low) restores register defaults and zeroes all
// voice phases at once through per-voice valid bits; no clearing pass.
module poly_quadrature_nco_with_expo_fm_unit import pqn_pkg::*; #(
    parameter int VOICES     = PQN_VOICES,
    parameter int SINE_DEPTH = PQN_SINE_DEPTH,
    parameter int EXP_DEPTH  = PQN_EXP_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   f_valid;
    logic   q_ready;
    t_qitem f_item;
    logic   q_valid;
    logic   q_pop;
    t_qitem q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_increment <= RST_BASE_INC;
            r_cfg.log2_base      <= RST_LOG2_BASE;
            r_cfg.tone_offset    <= signed'(RST_TONE);
            r_cfg.cv2_scale      <= RST_CV2_SCALE;
            r_cfg.phase_offset   <= RST_PH_OFS;
            r_cfg.range_a        <= RST_RANGE_A;
            r_cfg.range_b        <= RST_RANGE_B;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_INC:  r_cfg.base_increment <= i_cfg_data;
                CFG_LOG2_BASE: r_cfg.log2_base      <= i_cfg_data[15:0];
                CFG_TONE:      r_cfg.tone_offset    <= signed'(i_cfg_data[17:0]);
                CFG_CV2_SCALE: r_cfg.cv2_scale      <= i_cfg_data[15:0];
                CFG_PH_OFS:    r_cfg.phase_offset   <= i_cfg_data;
                CFG_RANGE_A:   r_cfg.range_a        <= i_cfg_data;
                CFG_RANGE_B:   r_cfg.range_b        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pqn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_item  (f_item)
    );

    pqn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    pqn_back #(
        .VOICES     (VOICES),
        .SINE_DEPTH (SINE_DEPTH),
        .EXP_DEPTH  (EXP_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_pop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back end popped twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !o_valid || $stable(o_data) || $past(i_ready))
        else $error("result changed without transfer");

endmodule

// ===== hdl/pqn_front.sv =====
// Front end: input register and exponent formation.
module pqn_front import pqn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_in    i_data,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    input  logic   i_ready,
    output t_qitem o_item
);

    logic               r_v;
    t_in                r_in;
    logic signed [32:0] prod;
    logic signed [17:0] scaled;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    // floor(cv2 * scale / 2^15)
    always_comb begin
        prod         = 33'(r_in.cv2) * signed'({17'd0, i_cfg.cv2_scale});
        scaled       = prod[32:15];
        o_item.voice = r_in.voice;
        o_item.e     = 20'(r_in.cv1) + 20'(scaled) + 20'(i_cfg.tone_offset);
    end

endmodule

// ===== hdl/pqn_queue.sv =====
// Two-entry queue between front and back.
module pqn_queue import pqn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    output logic   o_valid,
    input  logic   i_pop,
    output t_qitem o_item
);

    t_qitem     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== hdl/pqn_back.sv =====
// Back end: increment, phase update, sine lookup, range mapping, output register.
module pqn_back import pqn_pkg::*; #(
    parameter int VOICES     = PQN_VOICES,
    parameter int SINE_DEPTH = PQN_SINE_DEPTH,
    parameter int EXP_DEPTH  = PQN_EXP_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_qvalid,
    output logic   o_pop,
    input  t_qitem i_item,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    localparam int LS  = $clog2(SINE_DEPTH);
    localparam int LE  = $clog2(EXP_DEPTH);
    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef logic signed [15:0] t_sine_rom [SINE_DEPTH];
    typedef logic [31:0]        t_exp_rom  [EXP_DEPTH];
    typedef logic [VIW-1:0]     t_vmod     [16];

    function automatic t_sine_rom build_sine();
        t_sine_rom t;
        for (int i = 0; i < SINE_DEPTH; i++) t[i] = sine_entry(i, LS);
        return t;
    endfunction

    function automatic t_exp_rom build_exp();
        t_exp_rom t;
        for (int i = 0; i < EXP_DEPTH; i++) t[i] = exp_entry(i, LE);
        return t;
    endfunction

    function automatic t_vmod build_vmod();
        t_vmod t;
        for (int i = 0; i < 16; i++) t[i] = VIW'(i % VOICES);
        return t;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();
    localparam t_exp_rom  EXP_ROM  = build_exp();
    localparam t_vmod     VMOD     = build_vmod();

    typedef enum logic [2:0] {
        S_IDLE, S_OCT, S_EXP, S_INC, S_PH, S_SIN, S_MAP, S_OUT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_vin;
    logic [VIW-1:0]     r_vidx;
    logic signed [19:0] r_e;
    logic signed [15:0] r_sum;
    logic signed [36:0] r_p;
    logic [63:0]        r_m;
    logic signed [12:0] r_sh;
    logic [31:0]        r_inc;
    logic [31:0]        r_ph;
    logic [31:0]        r_ph_old;
    logic               r_ph_vld;
    logic signed [15:0] r_s1;
    logic signed [15:0] r_s2;
    logic [2:0]         r_cnt;
    logic signed [33:0] r_prod;
    logic signed [15:0] r_lo;
    logic signed [15:0] r_res [4];
    logic               r_ov;
    t_out               r_out;
    logic [31:0]        r_phase_mem [VOICES];
    logic [VOICES-1:0]  r_pv;

    logic signed [27:0] b;
    logic signed [11:0] k;
    logic signed [12:0] sh_n;
    logic [95:0]        wide;
    logic [63:0]        rs;
    logic [12:0]        nsh;
    logic [31:0]        inc;
    logic [31:0]        ph_new;
    logic [31:0]        ph2;
    logic signed [15:0] sel_s;
    logic [31:0]        sel_rng;
    logic signed [15:0] lo;
    logic signed [16:0] d;
    logic signed [16:0] u;
    logic signed [32:0] y;
    logic signed [17:0] q0;
    logic signed [19:0] rem;
    logic signed [2:0]  adj;
    logic signed [18:0] q;

    assign o_pop   = (r_state == S_IDLE) && i_qvalid;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        b    = r_p[36:9];
        k    = b[27:16];
        sh_n = {k[11], k} - 13'sd30;

        // saturating shift of the increment product
        wide = {32'd0, r_m} << r_sh[4:0];
        nsh  = 13'(-r_sh);
        rs   = r_m >> nsh[5:0];
        if (r_m == 64'd0) begin
            inc = 32'd0;
        end else if (!r_sh[12]) begin
            if ((r_sh[12:5] != 8'd0) || (wide[95:32] != 64'd0)) inc = '1;
            else inc = wide[31:0];
        end else begin
            if (nsh[12:6] != 7'd0) inc = 32'd0;
            else if (rs[63:32] != 32'd0) inc = '1;
            else inc = rs[31:0];
        end

        ph_new = (r_ph_vld ? r_ph_old : 32'd0) + r_inc;
        ph2    = r_ph + i_cfg.phase_offset;

        // range mapping product: (max - min) * (s + 32767)
        sel_s   = r_cnt[1] ? r_s2 : r_s1;
        sel_rng = r_cnt[0] ? i_cfg.range_b : i_cfg.range_a;
        lo      = signed'(sel_rng[15:0]);
        d       = {sel_rng[31], sel_rng[31:16]} - {sel_rng[15], sel_rng[15:0]};
        u       = {sel_s[15], sel_s} + 17'sd32767;

        // floor(prod / 65534) = floor(floor(prod / 2) / 32767)
        y   = r_prod[33:1];
        q0  = y[32:15];
        rem = signed'({5'd0, y[14:0]}) + {{2{q0[17]}}, q0};
        adj = 3'sd0;
        if (rem >= 20'sd32767) adj = 3'sd1;
        if (rem >= 20'sd65534) adj = 3'sd2;
        if (rem < 20'sd0) adj = -3'sd1;
        if (rem < -20'sd32767) adj = -3'sd2;
        if (rem < -20'sd65534) adj = -3'sd3;
        q = {q0[17], q0} + 19'(adj);
    end

    // phase store and sine table reads
    always_ff @(posedge i_clk) begin
        r_ph_old <= r_phase_mem[r_vidx];
        r_ph_vld <= r_pv[r_vidx];
        if (r_state == S_PH) begin
            r_phase_mem[r_vidx] <= ph_new;
        end
        r_s1 <= SINE_ROM[r_ph[31 -: LS]];
        r_s2 <= SINE_ROM[ph2[31 -: LS]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pv    <= '0;
            r_cnt   <= 3'd0;
        end else begin
            if (r_ov && i_ready && (r_state != S_OUT)) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_qvalid) begin
                        r_vin   <= i_item.voice;
                        r_vidx  <= VMOD[i_item.voice];
                        r_e     <= i_item.e;
                        r_state <= S_OCT;
                    end
                end
                S_OCT: begin
                    r_p <= 37'(r_e) * signed'({21'd0, i_cfg.log2_base});
                    if (r_e > SUM_LIMIT) r_sum <= 16'(SUM_LIMIT);
                    else if (r_e < -SUM_LIMIT) r_sum <= 16'(-SUM_LIMIT);
                    else r_sum <= r_e[15:0];
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_m     <= 64'(i_cfg.base_increment) * 64'(EXP_ROM[r_p[24 -: LE]]);
                    r_sh    <= sh_n;
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_inc   <= inc;
                    r_state <= S_PH;
                end
                S_PH: begin
                    r_ph         <= ph_new;
                    r_pv[r_vidx] <= 1'b1;
                    r_state      <= S_SIN;
                end
                S_SIN: begin
                    r_cnt   <= 3'd0;
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    // product for slot cnt, quotient for slot cnt-1
                    if (r_cnt != 3'd4) begin
                        r_prod <= 34'(d) * 34'(u);
                        r_lo   <= lo;
                    end
                    if (r_cnt != 3'd0) begin
                        r_res[2'(r_cnt - 3'd1)] <= r_lo + q[15:0];
                    end
                    if (r_cnt == 3'd4) r_state <= S_OUT;
                    r_cnt <= r_cnt + 3'd1;
                end
                S_OUT: begin
                    // a held result that is taken now is replaced in the same cycle
                    if (!r_ov || i_ready) begin
                        r_ov              <= 1'b1;
                        r_out.voice_out   <= r_vin;
                        r_out.sine_a      <= r_res[0];
                        r_out.sine_b      <= r_res[1];
                        r_out.shifted_a   <= r_res[2];
                        r_out.shifted_b   <= r_res[3];
                        r_out.sum_voltage <= r_sum;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the polyphonic quadrature NCO with exponential FM.
module tb_top import pqn_pkg::*; ();

    localparam int VOICES     = 16;
    localparam int SINE_DEPTH = 1024;
    localparam int EXP_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    poly_quadrature_nco_with_expo_fm_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // own copy of registers, phases and tables
    logic [31:0]        m_base_inc;
    logic [15:0]        m_log2_base;
    logic signed [17:0] m_tone;
    logic [15:0]        m_cv2_scale;
    logic [31:0]        m_ph_ofs;
    logic [31:0]        m_range_a;
    logic [31:0]        m_range_b;
    logic [31:0]        m_phase [VOICES];
    logic signed [15:0] sin_rom [SINE_DEPTH];
    logic [31:0]        exp_rom [EXP_DEPTH];

    t_out expected_q [$];
    int   n_errors = 0;
    int   n_results = 0;
    int   n_sent = 0;
    int   cycles = 0;

    function automatic longint unsigned qsine(longint unsigned r);
        longint unsigned th, t2, term;
        longint          acc;
        th = (r * PIH_Q30) >> 30;
        t2 = (th * th) >> 30;
        term = th;
        acc = longint'(th);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2) acc -= longint'(term); else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
        return longint'(acc);
    endfunction

    task automatic build_roms();
        longint unsigned a, r, s, v, fr, y, term, acc;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            a = (longint'(i) << 32) / SINE_DEPTH;
            r = a & 64'h3FFF_FFFF;
            if (a[30]) r = ONE_Q30 - r;
            s = qsine(r);
            v = (s * 32767 + (64'd1 << 29)) >> 30;
            sin_rom[i] = a[31] ? -16'(v) : 16'(v);
        end
        for (int i = 0; i < EXP_DEPTH; i++) begin
            fr = (longint'(i) << 30) / EXP_DEPTH;
            y = (fr * LN2_Q30) >> 30;
            term = ONE_Q30;
            acc = ONE_Q30;
            for (int n = 1; n <= 14; n++) begin
                term = ((term * y) >> 30) / longint'(n);
                acc += term;
            end
            exp_rom[i] = acc[31:0];
        end
    endtask

    task automatic model_defaults();
        m_base_inc = RST_BASE_INC;
        m_log2_base = RST_LOG2_BASE;
        m_tone = RST_TONE;
        m_cv2_scale = RST_CV2_SCALE;
        m_ph_ofs = RST_PH_OFS;
        m_range_a = RST_RANGE_A;
        m_range_b = RST_RANGE_B;
        foreach (m_phase[i]) m_phase[i] = '0;
    endtask

    function automatic logic signed [15:0] map_into(logic signed [15:0] s, logic [31:0] rng);
        longint lo, hi, prod, q;
        lo = longint'($signed(rng[15:0]));
        hi = longint'($signed(rng[31:16]));
        prod = (hi - lo) * (longint'(s) + 32767);
        q = (prod + 65536 * 65534) / 65534 - 65536;
        return 16'(lo + q);
    endfunction

    function automatic t_out nco_predict(t_in it);
        longint          scaled, e, p, k, sh, cv2;
        longint unsigned b, f, m, inc;
        logic [31:0]     ph, ph2;
        int              v;
        t_out            res;
        v = int'(it.voice) % VOICES;
        cv2 = longint'(it.cv2);
        scaled = longint'((unsigned'(cv2 * longint'(m_cv2_scale) + (64'sd1 <<< 40)))
                 >> 15) - (64'sd1 <<< 25);
        e = longint'(it.cv1) + scaled + longint'(m_tone);
        p = e * longint'(m_log2_base);
        b = unsigned'(p + (64'sd1 <<< 40)) >> 9;
        f = b & 64'hFFFF;
        k = longint'(b >> 16) - (64'sd1 <<< 15);
        m = 64'(m_base_inc) * 64'(exp_rom[((f * EXP_DEPTH) >> 16) % EXP_DEPTH]);
        sh = k - 30;
        if (m == 0) inc = 0;
        else if (sh >= 0) begin
            if (sh > 31 || m > (64'hFFFF_FFFF >> sh)) inc = 64'hFFFF_FFFF;
            else inc = m << sh;
        end else begin
            inc = (-sh >= 64) ? 64'd0 : (m >> (-sh));
            if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
        end
        ph = m_phase[v] + inc[31:0];
        m_phase[v] = ph;
        ph2 = ph + m_ph_ofs;
        res.voice_out = it.voice;
        res.sine_a    = map_into(sin_rom[ph[31:22]], m_range_a);
        res.sine_b    = map_into(sin_rom[ph[31:22]], m_range_b);
        res.shifted_a = map_into(sin_rom[ph2[31:22]], m_range_a);
        res.shifted_b = map_into(sin_rom[ph2[31:22]], m_range_b);
        if (e > 24576) e = 24576;
        if (e < -24576) e = -24576;
        res.sum_voltage = 16'(e);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure, compare on transfer
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            n_results <= n_results + 1;
            if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 0);
            else begin
                t_out w;
                w = expected_q.pop_front();
                if (o_data.voice_out !== w.voice_out)
                    report_mismatch("voice_out", o_data.voice_out, w.voice_out);
                if (o_data.sine_a !== w.sine_a) report_mismatch("sine_a", o_data.sine_a, w.sine_a);
                if (o_data.sine_b !== w.sine_b) report_mismatch("sine_b", o_data.sine_b, w.sine_b);
                if (o_data.shifted_a !== w.shifted_a)
                    report_mismatch("shifted_a", o_data.shifted_a, w.shifted_a);
                if (o_data.shifted_b !== w.shifted_b)
                    report_mismatch("shifted_b", o_data.shifted_b, w.shifted_b);
                if (o_data.sum_voltage !== w.sum_voltage)
                    report_mismatch("sum_voltage", o_data.sum_voltage, w.sum_voltage);
            end
        end
        if ($urandom_range(0, 99) < 8) i_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 60) i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays up after a transfer only when the next item follows at once
    task automatic send_sample(logic [3:0] voice, logic signed [15:0] cv1,
                               logic signed [15:0] cv2);
        t_in it;
        int  g;
        it.voice = voice;
        it.cv1 = cv1;
        it.cv2 = cv2;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(nco_predict(it));
        n_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        // drain, then let the pipeline settle before touching a register
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE_INC:  m_base_inc = val;
            CFG_LOG2_BASE: m_log2_base = val[15:0];
            CFG_TONE:      m_tone = val[17:0];
            CFG_CV2_SCALE: m_cv2_scale = val[15:0];
            CFG_PH_OFS:    m_ph_ofs = val;
            CFG_RANGE_A:   m_range_a = val;
            CFG_RANGE_B:   m_range_b = val;
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_cv();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom());
        if (r == 1) return ($urandom_range(0, 1)) ? 16'sd24576 : -16'sd24576;
        return 16'($signed($urandom_range(0, 49152)) - 24576);
    endfunction

    task automatic test_defaults_directed();
        send_sample(4'd0, 16'sd0, 16'sd0);
        send_sample(4'd15, 16'sd24576, 16'sd24576);
        send_sample(4'd1, -16'sd24576, -16'sd24576);
        send_sample(4'd2, 16'sh7FFF, 16'sh7FFF);
        send_sample(4'd3, 16'sh8000, 16'sh8000);
        send_sample(4'd15, 16'shFFFF, 16'sh5555);
        send_sample(4'd0, 16'shAAAA, 16'sh0001);
        send_sample(4'd5, 16'sd1536, 16'sd0);
    endtask

    task automatic test_saturation_and_ranges();
        write_reg(CFG_BASE_INC, 32'hFFFF_FFFF);
        write_reg(CFG_LOG2_BASE, 32'd49152);
        write_reg(CFG_TONE, 32'd98304);
        send_sample(4'd4, 16'sd24576, 16'sd24576);  // increment saturates
        send_sample(4'd4, 16'sh7FFF, 16'sh7FFF);
        write_reg(CFG_TONE, 32'h0002_8000);          // -98304: increment goes to zero
        send_sample(4'd6, -16'sd24576, -16'sd24576);
        write_reg(CFG_CV2_SCALE, 32'hFFFF);
        write_reg(CFG_PH_OFS, 32'hFFFF_FFFF);
        write_reg(CFG_RANGE_A, 32'h8000_7FFF);      // min above max: runs downward
        write_reg(CFG_RANGE_B, 32'h7FFF_8000);
        send_sample(4'd7, 16'sd100, 16'sh8000);
        send_sample(4'd7, 16'sh7FFF, 16'sh7FFF);
        write_reg(CFG_BASE_INC, 32'd0);
        write_reg(CFG_LOG2_BASE, 32'd0);
        write_reg(CFG_TONE, 32'h3FFFF);
        write_reg(CFG_CV2_SCALE, 32'd0);
        write_reg(CFG_PH_OFS, 32'd0);
        write_reg(CFG_RANGE_A, 32'd0);
        write_reg(CFG_RANGE_B, 32'hFFFF_FFFF);
        send_sample(4'd8, 16'sd5, 16'sh7FFF);
        send_sample(4'd9, 16'sh8000, -16'sd1);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_BASE_INC, $urandom());
            write_reg(CFG_LOG2_BASE, (phase % 4 == 0) ? $urandom() : $urandom_range(0, 49152));
            write_reg(CFG_TONE, (phase % 4 == 1) ? $urandom()
                                 : 32'($signed($urandom_range(0, 196608)) - 98304));
            write_reg(CFG_CV2_SCALE, (phase % 4 == 2) ? $urandom() : $urandom_range(0, 32768));
            write_reg(CFG_PH_OFS, $urandom());
            write_reg(CFG_RANGE_A, $urandom());
            write_reg(CFG_RANGE_B, $urandom());
            for (int n = 0; n < 200; n++)
                send_sample(4'($urandom()), rand_cv(), rand_cv());
        end
    endtask

    initial begin
        build_roms();
        model_defaults();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults_directed();
        test_saturation_and_ranges();
        test_random_phases();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d samples over default, directed and random register settings, "
                 , n_sent);
        $display("%0d results checked; saturating and vanishing increments, reversed ranges",
                 n_results);
        if (n_errors == 0 && expected_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/pqn_pkg.sv
hdl/pqn_front.sv
hdl/pqn_queue.sv
hdl/pqn_back.sv
hdl/poly_quadrature_nco_with_expo_fm_unit.sv
verif/tb_top.sv
